[src/tsph_pkg.sv]
// shared constants, types and the direction table entry function for transverse spherocity
// no dependencies
`default_nettype none
package tsph_pkg;
  localparam int MAX_PARTICLES_DEF = 1024;
  localparam int ANGLE_STEPS_DEF   = 100;
  localparam int MOMENTUM_BITS_DEF = 18;
  localparam int PT_SUM_W          = 29;
  localparam int SHAPE_W           = 16;
  localparam int DIR_W             = 17;   // q15 unit vector component, signed
  localparam int SERIES_TERMS      = 7;
  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint ONE_Q30              = 64'sd1073741824;
  localparam logic [PT_SUM_W-1:0] PT_SUM_MAX = '1;

  // taylor term divisors (2n)(2n+1) for sin and (2n-1)(2n) for cos
  localparam longint unsigned SIN_DIV [SERIES_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};
  localparam longint unsigned COS_DIV [SERIES_TERMS] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182};

  typedef struct packed {
    logic signed [DIR_W-1:0] nx;
    logic signed [DIR_W-1:0] ny;
  } dir_t;

  // datapath commands from the controller
  typedef struct packed {
    logic load;        // accept one particle into the stores
    logic clr_event;   // clear per-event state
    logic angle_start; // reset the angle accumulator and the best sum
    logic rd_issue;    // issue a store read
    logic acc_en;      // unused: the accumulator follows the read valid pipeline
    logic angle_done;  // compare accumulator against best
    logic div_start;
    logic div_step;
    logic sq_step;     // square stage
  } tsph_cmd_t;

  typedef struct packed {
    logic degen;
    logic ratio_ge1;
  } tsph_sts_t;

  function automatic longint q30_to_q15(input longint v);
    longint t;
    t = v;
    if (t < 0) t = 0;
    if (t > ONE_Q30) t = ONE_Q30;
    return (t + 64'sd16384) >>> 15;
  endfunction

  // elaboration-time only: one direction table entry from its q30 angle
  function automatic dir_t dir_entry(input longint unsigned a);
    longint unsigned x, x2, ts, tc;
    longint ss, cs, c, s;
    dir_t d;
    x = (a > HALF_PI_Q30) ? (PI_Q30 - a) : a;
    x2 = (x * x) >> 30;
    ts = x; tc = ONE_Q30;
    ss = ts; cs = tc;
    for (int i = 0; i < SERIES_TERMS; i++) begin
      ts = ((ts * x2) >> 30) / SIN_DIV[i];
      tc = ((tc * x2) >> 30) / COS_DIV[i];
      if ((i & 1) == 0) begin ss -= ts; cs -= tc; end
      else begin ss += ts; cs += tc; end
    end
    s = q30_to_q15(ss);
    c = q30_to_q15(cs);
    if (a > HALF_PI_Q30) c = -c;
    d.nx = DIR_W'(c);
    d.ny = DIR_W'(s);
    return d;
  endfunction
endpackage
`default_nettype wire

[src/tsph_ram.sv]
// generic single port write, single port read ram with registered read
// no dependencies
`default_nettype none
module tsph_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/tsph_sqrt.sv]
// iterative rounded integer square root, one result bit per cycle
// depends on nothing but its parameters
`default_nettype none
module tsph_sqrt #(
  parameter int IN_W = 64,
  localparam int RW = IN_W >> 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [IN_W-1:0]     radicand,
  output logic                     busy,
  output logic [RW:0]              root   // rounded
);
  localparam int CW = $clog2(RW+1);
  logic [IN_W-1:0] s_r, s_nxt, rem_r, rem_nxt;
  logic [RW:0]     r_r, r_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic [IN_W+1:0] trial;
  logic [IN_W+1:0] rem_sh;

  always_comb begin
    s_nxt = s_r; rem_nxt = rem_r; r_nxt = r_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    rem_sh = {rem_r, s_r[IN_W-1 -: 2]};
    trial  = {{(IN_W+1-RW-2){1'b0}}, r_r, 2'b01};
    if (start) begin
      s_nxt = radicand; rem_nxt = '0; r_nxt = '0; cnt_nxt = CW'(RW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      s_nxt = s_r << 2;
      if (rem_sh >= trial) begin
        rem_nxt = IN_W'(rem_sh - trial);
        r_nxt   = {r_r[RW-1:0], 1'b1};
      end else begin
        rem_nxt = IN_W'(rem_sh);
        r_nxt   = {r_r[RW-1:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    s_r <= s_nxt; rem_r <= rem_nxt; r_r <= r_nxt;
  end

  // remainder s - r^2 greater than r rounds up
  assign busy = busy_r;
  assign root = (rem_r > IN_W'(r_r)) ? r_r + 1'b1 : r_r;
endmodule
`default_nettype wire

[src/tsph_ctrl.sv]
// controller state machine for transverse spherocity
// depends on tsph_pkg
`default_nettype none
module tsph_ctrl #(
  parameter int MAX_PARTICLES = tsph_pkg::MAX_PARTICLES_DEF,
  parameter int ANGLE_STEPS   = tsph_pkg::ANGLE_STEPS_DEF,
  parameter int CNT_W         = $clog2(MAX_PARTICLES+1),
  parameter int ANG_W         = $clog2(ANGLE_STEPS)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_fire,
  input  wire logic            in_last,
  input  wire logic            sqrt_busy,
  input  wire logic [CNT_W-1:0] count,
  input  wire tsph_pkg::tsph_sts_t sts,
  input  wire logic            out_taken,
  output logic                 in_ready,
  output logic                 out_valid,
  output logic [ANG_W-1:0]     angle,
  output logic [CNT_W-1:0]     rd_idx,
  output tsph_pkg::tsph_cmd_t  cmd
);
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SQRT  = 8'b0000_0010,
    ST_SQWT  = 8'b0000_0100,
    ST_SCAN  = 8'b0000_1000,
    ST_DRAIN = 8'b0001_0000,
    ST_DIV   = 8'b0010_0000,
    ST_SQ    = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic            last_r, last_nxt;
  logic [ANG_W-1:0] ang_r, ang_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [5:0]      step_r, step_nxt;
  logic [1:0]      drn_r, drn_nxt;

  always_comb begin
    state_nxt = state_r; last_nxt = last_r; ang_nxt = ang_r; idx_nxt = idx_r;
    step_nxt = step_r; drn_nxt = drn_r;
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          last_nxt = in_last;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: state_nxt = ST_SQWT;   // sqrt started on load edge
      ST_SQWT: begin
        if (!sqrt_busy) begin
          if (!last_r) state_nxt = ST_IDLE;
          else if (sts.degen) state_nxt = ST_OUT;
          else begin
            cmd.angle_start = 1'b1;
            ang_nxt = '0; idx_nxt = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_issue = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == count - 1'b1) begin
          drn_nxt = 2'd0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait out the ram and product pipeline
        drn_nxt = drn_r + 1'b1;
        if (drn_r == 2'd3) begin
          cmd.angle_done = 1'b1;
          idx_nxt = '0;
          if (ang_r == ANG_W'(ANGLE_STEPS-1)) begin
            cmd.div_start = 1'b1;
            step_nxt = '0;
            state_nxt = ST_DIV;
          end else begin
            ang_nxt = ang_r + 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_DIV: begin
        if (sts.ratio_ge1) state_nxt = ST_OUT;
        else begin
          cmd.div_step = 1'b1;
          step_nxt = step_r + 1'b1;
          if (step_r == 6'd31) state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.sq_step = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_taken) begin
          cmd.clr_event = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake flags, scan angle and read index
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign angle     = ang_r;
  assign rd_idx    = idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      last_r  <= 1'b0;
      ang_r   <= '0;
      idx_r   <= '0;
      step_r  <= '0;
      drn_r   <= '0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
      ang_r   <= ang_nxt;
      idx_r   <= idx_nxt;
      step_r  <= step_nxt;
      drn_r   <= drn_nxt;
    end
  end
endmodule
`default_nettype wire

[src/tsph_dp.sv]
// datapath: particle stores, pt sum, projection accumulator, divider, square
// depends on tsph_pkg, tsph_ram and tsph_sqrt
`default_nettype none
module tsph_dp #(
  parameter int MAX_PARTICLES = tsph_pkg::MAX_PARTICLES_DEF,
  parameter int ANGLE_STEPS   = tsph_pkg::ANGLE_STEPS_DEF,
  parameter int MOMENTUM_BITS = tsph_pkg::MOMENTUM_BITS_DEF,
  parameter int CNT_W         = $clog2(MAX_PARTICLES+1),
  parameter int ANG_W         = $clog2(ANGLE_STEPS)
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire tsph_pkg::tsph_cmd_t             cmd,
  input  wire logic signed [MOMENTUM_BITS-1:0] mom_x,
  input  wire logic signed [MOMENTUM_BITS-1:0] mom_y,
  input  wire logic [ANG_W-1:0]                angle,
  input  wire logic [CNT_W-1:0]                rd_idx,
  output logic [CNT_W-1:0]                     count,
  output logic                                 sqrt_busy,
  output tsph_pkg::tsph_sts_t                  sts,
  output logic [tsph_pkg::SHAPE_W-1:0]         shape_value,
  output logic                                 degenerate,
  output logic                                 truncated
);
  localparam int AW   = $clog2(MAX_PARTICLES);
  localparam int MW   = MOMENTUM_BITS;
  localparam int SQW  = 2*MW;
  localparam int RTW  = MW + 1;
  localparam int PW   = MW + tsph_pkg::DIR_W + 1;
  localparam int ACCW = 64;
  localparam int PTW  = tsph_pkg::PT_SUM_W;
  localparam int DW   = PTW + 15;

  // direction table, constant
  tsph_pkg::dir_t dir_tab [ANGLE_STEPS];
  for (genvar k = 0; k < ANGLE_STEPS; k++) begin : g_dir
    localparam longint unsigned ANG_Q30 =
      (longint'(k) * tsph_pkg::PI_Q30) / ANGLE_STEPS;
    localparam tsph_pkg::dir_t DIR_K = tsph_pkg::dir_entry(ANG_Q30);
    assign dir_tab[k] = DIR_K;
  end

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTW-1:0]   pt_r, pt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             adding_r;
  logic             wr_en;
  logic [MW-1:0]    ax, ay;
  logic [SQW:0]     sumsq;
  logic [MW+1:0]    root;   // sqrt module output, IN_W = SQW+2
  logic signed [MW-1:0] xr, yr;
  logic             sbusy;

  assign wr_en = cmd.load && (cnt_r < CNT_W'(MAX_PARTICLES));
  assign ax = mom_x[MW-1] ? MW'(-mom_x) : MW'(mom_x);
  assign ay = mom_y[MW-1] ? MW'(-mom_y) : MW'(mom_y);
  assign sumsq = (SQW+1)'(ax) * (SQW+1)'(ax) + (SQW+1)'(ay) * (SQW+1)'(ay);

  tsph_ram #(.WIDTH(MW), .DEPTH(MAX_PARTICLES)) u_xram (
    .clk, .we(wr_en), .waddr(cnt_r[AW-1:0]), .wdata(mom_x),
    .raddr(rd_idx[AW-1:0]), .rdata(xr));
  tsph_ram #(.WIDTH(MW), .DEPTH(MAX_PARTICLES)) u_yram (
    .clk, .we(wr_en), .waddr(cnt_r[AW-1:0]), .wdata(mom_y),
    .raddr(rd_idx[AW-1:0]), .rdata(yr));

  tsph_sqrt #(.IN_W(SQW+2)) u_sqrt (
    .clk, .rst_n, .start(wr_en), .radicand((SQW+2)'(sumsq)),
    .busy(sbusy), .root(root));

  logic [PTW:0] pt_add;
  assign pt_add = (PTW+1)'(pt_r) + (PTW+1)'(root);

  always_comb begin
    cnt_nxt = cnt_r; pt_nxt = pt_r; ovf_nxt = ovf_r;
    if (cmd.clr_event) begin
      cnt_nxt = '0; pt_nxt = '0; ovf_nxt = 1'b0;
    end else begin
      if (cmd.load) begin
        if (wr_en) cnt_nxt = cnt_r + 1'b1;
        else ovf_nxt = 1'b1;
      end
      if (adding_r && !sbusy)
        pt_nxt = (pt_add > (PTW+1)'(tsph_pkg::PT_SUM_MAX)) ? tsph_pkg::PT_SUM_MAX
                                                           : PTW'(pt_add);
    end
  end

  // projection pipeline: read data -> products -> magnitude -> accumulate
  tsph_pkg::dir_t  dir_q;
  logic            v1_r, v2_r, v3_r;
  logic signed [PW-1:0] pa_r, pb_r;
  logic [PW-1:0]   mag_r;
  logic [ACCW-1:0] acc_r, best_r;
  logic [ACCW-1:0] best_min;
  logic signed [PW-1:0] diff;

  assign dir_q = dir_tab[angle];
  assign diff  = pa_r - pb_r;
  // best including the angle that is closing now
  assign best_min = (acc_r < best_r) ? acc_r : best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    pa_r  <= PW'($signed(dir_q.ny)) * PW'(xr);
    pb_r  <= PW'($signed(dir_q.nx)) * PW'(yr);
    mag_r <= diff[PW-1] ? PW'(-diff) : PW'(diff);
    if (cmd.angle_start) best_r <= '1;
    else if (cmd.angle_done) best_r <= best_min;
    if (cmd.angle_start || cmd.angle_done) acc_r <= '0;
    else if (v3_r) acc_r <= acc_r + ACCW'(mag_r);
  end

  // restoring division of the best sum by pt_sum * 2^15, 32 quotient bits
  logic [DW-1:0]  dvs;
  logic [DW:0]    rem_r, rem_sh;
  logic [31:0]    q_r;
  logic [63:0]    sq_r;
  logic           ge1;
  logic           degen_w;
  assign dvs = {pt_r, 15'd0};
  assign ge1 = (best_r >= ACCW'(dvs));
  assign rem_sh = {rem_r[DW-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= (DW+1)'(best_min < ACCW'(dvs) ? best_min : '0);
      q_r <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= (DW+1)'(dvs)) begin
        rem_r <= rem_sh - (DW+1)'(dvs);
        q_r <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r <= {q_r[30:0], 1'b0};
      end
    end
    if (cmd.sq_step) sq_r <= q_r * q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; pt_r <= '0; ovf_r <= 1'b0; adding_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt; pt_r <= pt_nxt; ovf_r <= ovf_nxt;
      adding_r <= cmd.clr_event ? 1'b0 : (wr_en ? 1'b1 : (sbusy ? adding_r : 1'b0));
    end
  end

  assign count       = cnt_r;
  assign sqrt_busy   = sbusy || adding_r;
  assign degen_w     = (cnt_r < CNT_W'(2)) || (pt_r == '0);
  assign sts         = {degen_w, ge1};
  assign degenerate  = degen_w;
  assign truncated   = ovf_r;
  assign shape_value = (degen_w || ge1) ? '1 : sq_r[63:48];
endmodule
`default_nettype wire

[src/transverse_spherocity.sv]
// top level of the transverse spherocity block
// depends on tsph_pkg, tsph_ctrl, tsph_dp (with tsph_ram, tsph_sqrt)
//
// input stream: one particle per transfer, in_tdata = {mom_y, mom_x}, in_tlast marks
// the last particle of an event. output stream: one transfer per event, on its last.
// each particle is held until the bit-serial square root of px^2+py^2 that feeds the
// pt sum is done. on the last particle of a non-degenerate event the scan walks the
// particle ram once per direction, ANGLE_STEPS directions, then comes a restoring
// division and the square, then the result.
// particles beyond MAX_PARTICLES are dropped and flagged truncated.
// the result holds in out_tdata/out_tuser while out_tready is low; no new particle
// is taken until it has gone. reset empties the event; the particle rams hold
// no meaningful data after reset and need no clearing since only entries
// written in the current event are read.
`default_nettype none
module transverse_spherocity #(
  parameter int MAX_PARTICLES = tsph_pkg::MAX_PARTICLES_DEF,
  parameter int ANGLE_STEPS   = tsph_pkg::ANGLE_STEPS_DEF,
  parameter int MOMENTUM_BITS = tsph_pkg::MOMENTUM_BITS_DEF,
  localparam int IN_BYTES     = (2*MOMENTUM_BITS + 7) / 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [8*IN_BYTES-1:0] in_tdata,   // mom_x, mom_y
  input  wire logic                  in_tlast,   // last
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [15:0]                out_tdata,  // shape_value
  output logic [1:0]                 out_tuser   // degenerate, truncated
);
  localparam int CNT_W = $clog2(MAX_PARTICLES+1);
  localparam int ANG_W = $clog2(ANGLE_STEPS);

  tsph_pkg::tsph_cmd_t cmd;
  tsph_pkg::tsph_sts_t sts;
  logic [CNT_W-1:0] count, rd_idx;
  logic [ANG_W-1:0] angle;
  logic sbusy, degen, trunc;

  tsph_ctrl #(.MAX_PARTICLES(MAX_PARTICLES), .ANGLE_STEPS(ANGLE_STEPS)) u_ctrl (
    .clk, .rst_n, .in_fire(in_tvalid && in_tready), .in_last(in_tlast),
    .sqrt_busy(sbusy), .count, .sts, .out_taken(out_tvalid && out_tready),
    .in_ready(in_tready), .out_valid(out_tvalid), .angle, .rd_idx, .cmd);

  tsph_dp #(.MAX_PARTICLES(MAX_PARTICLES), .ANGLE_STEPS(ANGLE_STEPS),
            .MOMENTUM_BITS(MOMENTUM_BITS)) u_dp (
    .clk, .rst_n, .cmd,
    .mom_x(in_tdata[MOMENTUM_BITS-1:0]),
    .mom_y(in_tdata[2*MOMENTUM_BITS-1:MOMENTUM_BITS]),
    .angle, .rd_idx, .count, .sqrt_busy(sbusy), .sts,
    .shape_value(out_tdata), .degenerate(degen), .truncated(trunc));

  assign out_tuser = {trunc, degen};
endmodule
`default_nettype wire

[src/tsph_chk.sv]
// port-level checker for transverse spherocity, bound to the top level
// depends on the top level ports only
`default_nettype none
module tsph_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic [1:0]  out_tuser
);
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped under stall");
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 16'hFFFF)
    else $error("degenerate result not full scale");
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("particle taken back to back");
endmodule

bind transverse_spherocity tsph_chk u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tuser);
`default_nettype wire

[tb/sv/tb_transverse_spherocity.sv]
// self-checking testbench for transverse_spherocity: particle stream in, one shape result per event
// depends on tsph_pkg and the transverse_spherocity rtl; carries its own shape predictor
`default_nettype none
module tb_transverse_spherocity;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MB       = tsph_pkg::MOMENTUM_BITS_DEF;
  localparam int CAPACITY = tsph_pkg::MAX_PARTICLES_DEF;
  localparam int STEPS    = tsph_pkg::ANGLE_STEPS_DEF;
  localparam int N_ITEMS  = 750;
  localparam int QUIET_AT = 80;   // no idling for this many final items

  typedef struct {
    logic signed [MB-1:0] px;
    logic signed [MB-1:0] py;
    logic                 last;
    bit                   fixed;  // expected result typed in below
    logic [15:0]          shape;
    logic                 degen;
    logic                 trunc;
  } particle_t;

  typedef struct {
    logic [15:0] shape;
    logic        degen;
    logic        trunc;
  } shape_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid, in_tlast, in_tready;
  logic [39:0] in_tdata;   // mom_x [17:0], mom_y [35:18], zero fill
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;  // shape_value
  logic [1:0]  out_tuser;  // degenerate [0], truncated [1]

  transverse_spherocity DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  particle_t  stim[$];
  shape_res_t shapes_due[$];
  int         errors = 0;
  bit         quiet = 1'b0;

  // predictor state
  longint dir_cos[STEPS];
  longint dir_sin[STEPS];
  longint ev_x[$];
  longint ev_y[$];
  longint unsigned ev_pt_sum = 0;
  bit     ev_dropped = 0;

  function automatic longint to_q15(longint v);
    if (v < 0) v = 0;
    if (v > 64'sd1073741824) v = 64'sd1073741824;
    return (v + 16384) >>> 15;
  endfunction

  // taylor series sin/cos in q30, folded about pi/2
  task automatic build_directions();
    longint unsigned ang, x, x2, ts, tc;
    longint ss, cs;
    for (int k = 0; k < STEPS; k++) begin
      ang = (longint'(k) * tsph_pkg::PI_Q30) / STEPS;
      x = (ang > tsph_pkg::HALF_PI_Q30) ? tsph_pkg::PI_Q30 - ang : ang;
      x2 = (x * x) >> 30;
      ts = x;
      tc = 64'd1073741824;
      ss = ts;
      cs = tc;
      for (int n = 1; n <= 7; n++) begin
        ts = ((ts * x2) >> 30) / ((2*n) * (2*n+1));
        tc = ((tc * x2) >> 30) / ((2*n-1) * (2*n));
        if (n % 2 == 1) begin
          ss -= ts; cs -= tc;
        end else begin
          ss += ts; cs += tc;
        end
      end
      dir_sin[k] = to_q15(ss);
      dir_cos[k] = (ang > tsph_pkg::HALF_PI_Q30) ? -to_q15(cs) : to_q15(cs);
    end
  endtask

  function automatic longint unsigned rounded_pt(longint px, longint py);
    longint unsigned s, r, t;
    s = px * px + py * py;
    r = 0;
    for (int b = 18; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= s) r = t;
    end
    if (s - r * r > r) r++;
    return r;
  endfunction

  function automatic shape_res_t event_shape();
    shape_res_t res;
    longint unsigned best, acc, d, rem, q;
    longint p;
    res.trunc = ev_dropped;
    res.degen = (ev_x.size() < 2) || (ev_pt_sum == 0);
    res.shape = 16'hFFFF;
    if (res.degen) return res;
    best = '1;
    for (int k = 0; k < STEPS; k++) begin
      acc = 0;
      foreach (ev_x[i]) begin
        p = dir_sin[k] * ev_x[i] - dir_cos[k] * ev_y[i];
        acc += (p < 0) ? -p : p;
      end
      if (acc < best) best = acc;
    end
    d = ev_pt_sum << 15;
    if (best >= d) return res;
    rem = best;
    q = 0;
    for (int b = 0; b < 32; b++) begin
      rem <<= 1;
      q <<= 1;
      if (rem >= d) begin
        rem -= d; q |= 1;
      end
    end
    res.shape = 16'((q * q) >> 48);
    return res;
  endfunction

  // update event state with one accepted particle, return 1 when a result is due
  function automatic bit take_particle(particle_t it, output shape_res_t res);
    if (ev_x.size() < CAPACITY) begin
      ev_x = {ev_x, longint'(it.px)};
      ev_y = {ev_y, longint'(it.py)};
      ev_pt_sum += rounded_pt(longint'(it.px), longint'(it.py));
      if (ev_pt_sum > 64'd536870911) ev_pt_sum = 64'd536870911;
    end else begin
      ev_dropped = 1;
    end
    if (!it.last) return 0;
    res = event_shape();
    ev_x.delete();
    ev_y.delete();
    ev_pt_sum = 0;
    ev_dropped = 0;
    return 1;
  endfunction

  function automatic particle_t mk(int x, int y, bit last, bit fixed = 0,
                                   int shp = 0, bit dg = 0, bit tr = 0);
    particle_t p;
    p.px = MB'(x); p.py = MB'(y); p.last = last;
    p.fixed = fixed; p.shape = 16'(shp); p.degen = dg; p.trunc = tr;
    return p;
  endfunction

  function automatic int rand_mom(int mode);
    case (mode)
      0: return int'($signed(MB'($urandom())));
      1: return $urandom_range(0, 400) - 200;
      2: return $urandom_range(0, 1) ? 131071 : -131072;
      default: return 0;
    endcase
  endfunction

  task automatic add_random_event(int n);
    int mode, x, y;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < n; i++) begin
      x = rand_mom(mode < 5 ? 0 : (mode < 8 ? 1 : ($urandom_range(0, 3) == 0 ? 2 : 0)));
      y = rand_mom(mode < 5 ? 0 : (mode < 8 ? 1 : ($urandom_range(0, 3) == 0 ? 2 : 0)));
      if (mode == 9) y = x;                // pencil-like event
      if ($urandom_range(0, 30) == 0) begin
        x = 0; y = 0;
      end
      stim = {stim, mk(x, y, i == n - 1)};
    end
  endtask

  task automatic build_stimulus();
    particle_t dir_tab[$];
    int n;
    dir_tab = '{
      mk(5, 7, 1, 1, 65535, 1, 0),                                // lone particle
      mk(0, 0, 0), mk(0, 0, 1, 1, 65535, 1, 0),                   // zero pt sum
      mk(1000, 0, 0), mk(-500, 0, 1, 1, 0, 0, 0),                 // back to back on x
      mk(131071, 131071, 0), mk(-131072, -131072, 1),             // extremes
      mk(131071, -131072, 0), mk(-131072, 131071, 0), mk(0, 131071, 1),
      mk(-1, -1, 0), mk(1, -1, 0), mk(-1, 1, 1),
      mk(100, 0, 0), mk(0, 100, 0), mk(-100, 0, 0), mk(0, -100, 1), // isotropic
      mk(0, 0, 0), mk(3, 4, 1),
      mk(-131072, 0, 0), mk(0, -131072, 0), mk(131071, 0, 0), mk(0, 131071, 1)
    };
    foreach (dir_tab[i]) stim = {stim, dir_tab[i]};
    while (stim.size() < N_ITEMS) begin
      n = $urandom_range(0, 9);
      n = (n == 0) ? 1 : (n < 8 ? $urandom_range(2, 12) : $urandom_range(13, 40));
      add_random_event(n);
    end
  endtask

  // sender
  initial begin
    shape_res_t res;
    int gap;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    build_directions();
    build_stimulus();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (stim[i]) begin
      if (stim.size() - i <= QUIET_AT) quiet = 1'b1;
      gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= {4'b0, stim[i].py, stim[i].px};
      in_tlast  <= stim[i].last;
      do @(posedge clk); while (!in_tready);
      if (take_particle(stim[i], res)) begin
        if (stim[i].fixed) begin
          res.shape = stim[i].shape; res.degen = stim[i].degen; res.trunc = stim[i].trunc;
        end
        shapes_due = {shapes_due, res};
      end
    end
    in_tvalid <= 1'b0;
    while (shapes_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // receiver: checks each transfer and stalls in bursts
  int stall_left = 0;
  always @(posedge clk) begin
    shape_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (shapes_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result shape=%0d flags=%b", out_tdata, out_tuser);
      end else begin
        want = shapes_due.pop_front();
        if (out_tdata !== want.shape || out_tuser[0] !== want.degen ||
            out_tuser[1] !== want.trunc) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected shape=%0d degen=%b trunc=%b, got shape=%0d flags=%b",
                     want.shape, want.degen, want.trunc, out_tdata, out_tuser);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    #15ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire
